// File: rtl/vgmcsc_pkg.sv
`default_nettype none

package vgmcsc_pkg;

   localparam int BYTE_WIDTH   = 8;
   localparam int SAMPLE_WIDTH = 16;
   localparam int TICK_WIDTH   = 8;
   localparam int WORD_WIDTH   = 32;
   localparam int POS_WIDTH    = 6;
   localparam int OPIDX_WIDTH  = 3;
   localparam int CSR_WIDTH    = 2;
   localparam int STEP_WIDTH   = 4;

   typedef enum logic [3:0] {
      PH_MAGIC  = 4'd0,
      PH_HEADER = 4'd1,
      PH_OFFSET = 4'd2,
      PH_LEAD   = 4'd3,
      PH_CMD    = 4'd4,
      PH_CHIP   = 4'd5,
      PH_WAIT   = 4'd6,
      PH_SKIP   = 4'd7,
      PH_BLOCK  = 4'd8
   } phase_type;

   typedef enum logic [0:0] {
      SQ_IDLE   = 1'b0,
      SQ_DIVIDE = 1'b1
   } seq_type;

   typedef enum logic [1:0] {
      OC_RECORD = 2'd0,
      OC_DONE   = 2'd1,
      OC_ERROR  = 2'd2
   } outcome_type;

   typedef struct packed {
      logic                  busy;
      logic [TICK_WIDTH-1:0] quotient;
   } div_status_type;

   localparam logic [CSR_WIDTH-1:0] CSR_SAMPLES_PER_TICK = 2'd0;
   localparam logic [CSR_WIDTH-1:0] CSR_DELAY_CODE       = 2'd1;
   localparam logic [CSR_WIDTH-1:0] CSR_DONE_CODE        = 2'd2;

   localparam logic [SAMPLE_WIDTH-1:0] SAMPLES_PER_TICK_RESET = 16'd735;
   localparam logic [BYTE_WIDTH-1:0]   DELAY_CODE_RESET       = 8'd2;
   localparam logic [BYTE_WIDTH-1:0]   DONE_CODE_RESET        = 8'd4;

   localparam logic [BYTE_WIDTH-1:0] CMD_CHIP_WRITE = 8'h54;
   localparam logic [BYTE_WIDTH-1:0] CMD_WAIT       = 8'h61;
   localparam logic [BYTE_WIDTH-1:0] CMD_WAIT_ONE   = 8'h62;
   localparam logic [BYTE_WIDTH-1:0] CMD_END        = 8'h66;
   localparam logic [BYTE_WIDTH-1:0] CMD_SKIP_THREE = 8'hc0;
   localparam logic [BYTE_WIDTH-1:0] CMD_DATA_BLOCK = 8'h67;

   localparam logic [POS_WIDTH-1:0]  MAGIC_LAST_POS  = 6'h03;
   localparam logic [POS_WIDTH-1:0]  HEADER_LAST_POS = 6'h33;
   localparam logic [WORD_WIDTH-1:0] LEAD_BIAS       = 32'd4;
   localparam logic [WORD_WIDTH-1:0] EARLY_LIMIT     = 32'hffff_ffc8;

   function automatic logic [BYTE_WIDTH-1:0] magic_byte(input logic [1:0] idx);
      logic [BYTE_WIDTH-1:0] result;
      case (idx)
         2'd0:    result = 8'h56;
         2'd1:    result = 8'h67;
         2'd2:    result = 8'h6d;
         default: result = 8'h20;
      endcase
      return result;
   endfunction

endpackage

`default_nettype wire

// File: rtl/vgmcsc_div.sv
`default_nettype none

module vgmcsc_div (
   input  wire                                          clock,
   input  wire                                          reset,
   input  wire                                          start,
   input  wire  [vgmcsc_pkg::SAMPLE_WIDTH-1:0]          dividend,
   input  wire  [vgmcsc_pkg::SAMPLE_WIDTH-1:0]          divisor,
   output vgmcsc_pkg::div_status_type                   status
);

   localparam int W = vgmcsc_pkg::SAMPLE_WIDTH;

   logic                                  busy_ff, busy_in;
   logic [vgmcsc_pkg::STEP_WIDTH-1:0]     count_ff, count_in;
   logic [W-1:0]                          rem_ff, rem_in;
   logic [W-1:0]                          quo_ff, quo_in;
   logic [W-1:0]                          divisor_ff, divisor_in;
   logic [W:0]                            rem_shift;
   logic [W+1:0]                          diff;

   always_comb begin
      busy_in    = busy_ff;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      rem_shift  = {rem_ff, quo_ff[W-1]};
      diff       = {1'b0, rem_shift} - {2'b00, divisor_ff};
      if (start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         rem_in     = '0;
         quo_in     = dividend;
         divisor_in = divisor;
      end else if (busy_ff) begin
         if (!diff[W+1]) begin
            rem_in = diff[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         count_in = count_ff + 1'b1;
         if (count_ff == '1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign status.busy     = busy_ff;
   assign status.quotient = quo_ff[vgmcsc_pkg::TICK_WIDTH-1:0];

endmodule

`default_nettype wire

// File: rtl/vgm_command_stream_converter.sv
`default_nettype none

// Converts a music log file, delivered one byte per transfer with tlast marking the end of the
// file, into two-byte register records. Each byte transfer is taken without a stall, except
// the second operand byte of a wait command, which starts a restoring divider that produces one
// quotient bit per cycle: that byte keeps the input stalled until its record is stored. The input
// also stalls whenever a finished record waits in the output register and rsp_tready is low.
// Configuration writes are taken at any time but must only be issued while the block is idle.

module vgm_command_stream_converter (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // file_byte [7:0]
   input  wire         req_tlast,   // file_end
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,   // rec_reg [7:0], rec_value [15:8]
   output logic [1:0]  rsp_tuser,   // outcome [1:0]
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [1:0]  csr_index,
   input  wire  [15:0] csr_data
);

   localparam int BW = vgmcsc_pkg::BYTE_WIDTH;
   localparam int WW = vgmcsc_pkg::WORD_WIDTH;

   logic [vgmcsc_pkg::SAMPLE_WIDTH-1:0]  spt_ff, spt_in;
   logic [BW-1:0]                        delay_code_ff, delay_code_in;
   logic [BW-1:0]                        done_code_ff, done_code_in;

   vgmcsc_pkg::phase_type                phase_ff, phase_in;
   logic [vgmcsc_pkg::POS_WIDTH-1:0]     pos_ff, pos_in;
   logic [WW-1:0]                        data_start_ff, data_start_in;
   logic [WW-1:0]                        skip_ff, skip_in;
   logic [vgmcsc_pkg::OPIDX_WIDTH-1:0]   opidx_ff, opidx_in;
   logic [BW-1:0]                        held_ff, held_in;
   logic                                 stopped_ff, stopped_in;
   vgmcsc_pkg::seq_type                  seq_ff, seq_in;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0]                        rsp_reg_ff, rsp_reg_in;
   logic [BW-1:0]                        rsp_value_ff, rsp_value_in;
   vgmcsc_pkg::outcome_type              rsp_outcome_ff, rsp_outcome_in;

   logic                                 req_accept;
   logic                                 out_free;
   logic                                 emit;
   logic [BW-1:0]                        emit_reg;
   logic [BW-1:0]                        emit_value;
   vgmcsc_pkg::outcome_type              emit_outcome;
   logic                                 div_start;
   logic                                 div_finish;
   logic                                 mismatch;
   logic [WW-1:0]                        ds_next;
   logic [WW-1:0]                        skip_next;
   logic [WW-1:0]                        lead;
   logic [4:0]                           lane_sel;
   vgmcsc_pkg::div_status_type           div_status;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (seq_ff == vgmcsc_pkg::SQ_IDLE) && out_free;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      spt_in        = spt_ff;
      delay_code_in = delay_code_ff;
      done_code_in  = done_code_ff;
      if (csr_valid) begin
         case (csr_index)
            vgmcsc_pkg::CSR_SAMPLES_PER_TICK: spt_in        = csr_data;
            vgmcsc_pkg::CSR_DELAY_CODE:       delay_code_in = csr_data[BW-1:0];
            vgmcsc_pkg::CSR_DONE_CODE:        done_code_in  = csr_data[BW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      pos_in        = pos_ff;
      data_start_in = data_start_ff;
      skip_in       = skip_ff;
      opidx_in      = opidx_ff;
      held_in       = held_ff;
      stopped_in    = stopped_ff;
      emit          = 1'b0;
      emit_reg      = '0;
      emit_value    = '0;
      emit_outcome  = vgmcsc_pkg::OC_RECORD;
      div_start     = 1'b0;
      mismatch      = 1'b0;
      ds_next       = data_start_ff;
      skip_next     = skip_ff;
      lead          = '0;
      lane_sel      = '0;
      if (req_accept) begin
         if (req_tlast) begin
            if (!stopped_ff && phase_ff == vgmcsc_pkg::PH_MAGIC) begin
               emit         = 1'b1;
               emit_reg     = done_code_ff;
               emit_outcome = vgmcsc_pkg::OC_DONE;
            end
            phase_in      = vgmcsc_pkg::PH_MAGIC;
            pos_in        = '0;
            data_start_in = '0;
            skip_in       = '0;
            opidx_in      = '0;
            held_in       = '0;
            stopped_in    = 1'b0;
         end else if (!stopped_ff) begin
            if (pos_ff != '1) begin
               pos_in = pos_ff + 1'b1;
            end
            case (phase_ff)
               vgmcsc_pkg::PH_MAGIC: begin
                  mismatch = held_ff[0] || (req_tdata != vgmcsc_pkg::magic_byte(pos_ff[1:0]));
                  held_in  = {{(BW-1){1'b0}}, mismatch};
                  if (pos_ff == vgmcsc_pkg::MAGIC_LAST_POS) begin
                     if (mismatch) begin
                        stopped_in   = 1'b1;
                        emit         = 1'b1;
                        emit_outcome = vgmcsc_pkg::OC_ERROR;
                     end else begin
                        held_in  = '0;
                        phase_in = vgmcsc_pkg::PH_HEADER;
                     end
                  end
               end
               vgmcsc_pkg::PH_HEADER: begin
                  if (pos_ff == vgmcsc_pkg::HEADER_LAST_POS) begin
                     phase_in      = vgmcsc_pkg::PH_OFFSET;
                     opidx_in      = '0;
                     data_start_in = '0;
                  end
               end
               vgmcsc_pkg::PH_OFFSET: begin
                  lane_sel = {opidx_ff[1:0], 3'b000};
                  ds_next[lane_sel +: BW] = data_start_ff[lane_sel +: BW] | req_tdata;
                  data_start_in = ds_next;
                  opidx_in      = opidx_ff + 1'b1;
                  lead          = ds_next - vgmcsc_pkg::LEAD_BIAS;
                  if (opidx_ff == 3'd3) begin
                     opidx_in = '0;
                     if (lead >= vgmcsc_pkg::EARLY_LIMIT) begin
                        stopped_in   = 1'b1;
                        emit         = 1'b1;
                        emit_outcome = vgmcsc_pkg::OC_ERROR;
                     end else begin
                        skip_in  = lead;
                        phase_in = (lead == '0) ? vgmcsc_pkg::PH_CMD : vgmcsc_pkg::PH_LEAD;
                     end
                  end
               end
               vgmcsc_pkg::PH_LEAD, vgmcsc_pkg::PH_SKIP: begin
                  if (skip_ff != '0) begin
                     skip_next = skip_ff - 1'b1;
                  end
                  skip_in = skip_next;
                  if (skip_next == '0) begin
                     phase_in = vgmcsc_pkg::PH_CMD;
                  end
               end
               vgmcsc_pkg::PH_CHIP: begin
                  if (opidx_ff == '0) begin
                     held_in  = req_tdata;
                     opidx_in = 3'd1;
                  end else begin
                     emit       = 1'b1;
                     emit_reg   = held_ff;
                     emit_value = req_tdata;
                     phase_in   = vgmcsc_pkg::PH_CMD;
                     opidx_in   = '0;
                  end
               end
               vgmcsc_pkg::PH_WAIT: begin
                  if (opidx_ff == '0) begin
                     held_in  = req_tdata;
                     opidx_in = 3'd1;
                  end else begin
                     div_start = 1'b1;
                     phase_in  = vgmcsc_pkg::PH_CMD;
                     opidx_in  = '0;
                  end
               end
               vgmcsc_pkg::PH_BLOCK: begin
                  if (opidx_ff >= 3'd2) begin
                     lane_sel = {opidx_ff[1:0] - 2'd2, 3'b000};
                     skip_next[lane_sel +: BW] = skip_ff[lane_sel +: BW] | req_tdata;
                  end
                  skip_in  = skip_next;
                  opidx_in = opidx_ff + 1'b1;
                  if (opidx_ff == 3'd5) begin
                     opidx_in = '0;
                     phase_in = (skip_next == '0) ? vgmcsc_pkg::PH_CMD : vgmcsc_pkg::PH_SKIP;
                  end
               end
               vgmcsc_pkg::PH_CMD: begin
                  case (req_tdata)
                     vgmcsc_pkg::CMD_CHIP_WRITE: begin
                        phase_in = vgmcsc_pkg::PH_CHIP;
                        opidx_in = '0;
                     end
                     vgmcsc_pkg::CMD_WAIT: begin
                        phase_in = vgmcsc_pkg::PH_WAIT;
                        opidx_in = '0;
                     end
                     vgmcsc_pkg::CMD_WAIT_ONE: begin
                        emit       = 1'b1;
                        emit_reg   = delay_code_ff;
                        emit_value = 8'd1;
                     end
                     vgmcsc_pkg::CMD_END: begin
                        stopped_in   = 1'b1;
                        emit         = 1'b1;
                        emit_reg     = done_code_ff;
                        emit_outcome = vgmcsc_pkg::OC_DONE;
                     end
                     vgmcsc_pkg::CMD_SKIP_THREE: begin
                        phase_in = vgmcsc_pkg::PH_SKIP;
                        skip_in  = 32'd3;
                     end
                     vgmcsc_pkg::CMD_DATA_BLOCK: begin
                        phase_in = vgmcsc_pkg::PH_BLOCK;
                        opidx_in = '0;
                        skip_in  = '0;
                     end
                     default: ;
                  endcase
               end
               default: begin
                  phase_in = vgmcsc_pkg::PH_CMD;
               end
            endcase
         end
      end
   end

   vgmcsc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({req_tdata, held_ff}),
      .divisor  (spt_ff),
      .status   (div_status)
   );

   always_comb begin
      seq_in     = seq_ff;
      div_finish = 1'b0;
      case (seq_ff)
         vgmcsc_pkg::SQ_IDLE: begin
            if (div_start) begin
               seq_in = vgmcsc_pkg::SQ_DIVIDE;
            end
         end
         vgmcsc_pkg::SQ_DIVIDE: begin
            if (!div_status.busy && out_free) begin
               div_finish = 1'b1;
               seq_in     = vgmcsc_pkg::SQ_IDLE;
            end
         end
         default: begin
            seq_in = vgmcsc_pkg::SQ_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_reg_in     = rsp_reg_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_outcome_in = rsp_outcome_ff;
      if (emit) begin
         rsp_valid_in   = 1'b1;
         rsp_reg_in     = emit_reg;
         rsp_value_in   = emit_value;
         rsp_outcome_in = emit_outcome;
      end else if (div_finish) begin
         rsp_valid_in   = 1'b1;
         rsp_reg_in     = delay_code_ff;
         rsp_value_in   = div_status.quotient;
         rsp_outcome_in = vgmcsc_pkg::OC_RECORD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spt_ff        <= vgmcsc_pkg::SAMPLES_PER_TICK_RESET;
         delay_code_ff <= vgmcsc_pkg::DELAY_CODE_RESET;
         done_code_ff  <= vgmcsc_pkg::DONE_CODE_RESET;
         phase_ff      <= vgmcsc_pkg::PH_MAGIC;
         pos_ff        <= '0;
         data_start_ff <= '0;
         skip_ff       <= '0;
         opidx_ff      <= '0;
         held_ff       <= '0;
         stopped_ff    <= 1'b0;
         seq_ff        <= vgmcsc_pkg::SQ_IDLE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         spt_ff        <= spt_in;
         delay_code_ff <= delay_code_in;
         done_code_ff  <= done_code_in;
         phase_ff      <= phase_in;
         pos_ff        <= pos_in;
         data_start_ff <= data_start_in;
         skip_ff       <= skip_in;
         opidx_ff      <= opidx_in;
         held_ff       <= held_in;
         stopped_ff    <= stopped_in;
         seq_ff        <= seq_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_reg_ff     <= rsp_reg_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_outcome_ff <= rsp_outcome_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_value_ff, rsp_reg_ff};
   assign rsp_tuser  = rsp_outcome_ff;

   // The divider only runs while the sequencer waits for its quotient.
   a_div_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> seq_ff == vgmcsc_pkg::SQ_DIVIDE)
      else $error("divider busy outside the divide state");

   // A byte taken after the parser has stopped produces no result.
   a_stopped_silent: assert property (@(posedge clock) disable iff (reset)
      req_accept && stopped_ff && !req_tlast |=> !rsp_tvalid)
      else $error("result produced while stopped");

   // Header errors only come from the magic or offset phases.
   a_error_source: assert property (@(posedge clock) disable iff (reset)
      req_accept && !req_tlast && phase_ff != vgmcsc_pkg::PH_MAGIC
         && phase_ff != vgmcsc_pkg::PH_OFFSET
      |=> !(rsp_tvalid && rsp_tuser == vgmcsc_pkg::OC_ERROR))
      else $error("error result outside header parsing");

   // While skipping, there is always at least one byte left to skip.
   a_skip_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == vgmcsc_pkg::PH_LEAD || phase_ff == vgmcsc_pkg::PH_SKIP) |-> skip_ff != '0)
      else $error("skip phase with nothing left to skip");

endmodule

`default_nettype wire

// File: dv/vgm_command_stream_converter_tb.sv
`default_nettype none

module vgm_command_stream_converter_tb;

   typedef logic [7:0] byte_queue_type [$];

   typedef struct packed {
      logic [7:0]              rec_reg;
      logic [7:0]              rec_value;
      vgmcsc_pkg::outcome_type outcome;
   } rec_type;

   typedef enum logic [1:0] {
      ROW_BYTE,
      ROW_END,
      ROW_FILL,
      ROW_HDR
   } row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [31:0]  arg;
      logic         typed;
      rec_type      want;
   } dir_row_type;

   localparam logic [vgmcsc_pkg::CSR_WIDTH-1:0] CSR_UNUSED = 2'd3;
   localparam logic [31:0] HDR_OFFSET_POS = 32'h34;
   localparam logic [31:0] HDR_END_POS    = 32'h38;
   localparam int SETTLE_CYCLES = 40;
   localparam logic [7:0] MAGIC_WORD [4] = '{8'h56, 8'h67, 8'h6d, 8'h20};

   localparam rec_type NO_REC         = '{8'h00, 8'h00, vgmcsc_pkg::OC_RECORD};
   localparam rec_type ERROR_REC      = '{8'h00, 8'h00, vgmcsc_pkg::OC_ERROR};
   localparam rec_type DONE_RESET_REC = '{vgmcsc_pkg::DONE_CODE_RESET, 8'h00,
                                          vgmcsc_pkg::OC_DONE};

   // A FILL row repeats the byte in bits 7:0 as many times as bits 15:8 say.
   localparam dir_row_type DIRECTED [26] = '{
      '{ROW_BYTE, 32'h56,        1'b0, NO_REC},
      '{ROW_END,  32'h00,        1'b1, DONE_RESET_REC},
      '{ROW_BYTE, 32'hff,        1'b0, NO_REC},
      '{ROW_BYTE, 32'h00,        1'b0, NO_REC},
      '{ROW_BYTE, 32'h6d,        1'b0, NO_REC},
      '{ROW_BYTE, 32'h20,        1'b1, ERROR_REC},
      '{ROW_BYTE, 32'h62,        1'b0, NO_REC},
      '{ROW_END,  32'hff,        1'b0, NO_REC},
      '{ROW_HDR,  32'hffff_ffcc, 1'b1, ERROR_REC},
      '{ROW_END,  32'h00,        1'b0, NO_REC},
      '{ROW_HDR,  32'h5,         1'b0, NO_REC},
      '{ROW_BYTE, 32'h66,        1'b0, NO_REC},
      '{ROW_BYTE, 32'h54,        1'b0, NO_REC},
      '{ROW_BYTE, 32'h00,        1'b0, NO_REC},
      '{ROW_BYTE, 32'hff,        1'b1, '{8'h00, 8'hff, vgmcsc_pkg::OC_RECORD}},
      '{ROW_BYTE, 32'h62,        1'b1,
        '{vgmcsc_pkg::DELAY_CODE_RESET, 8'h01, vgmcsc_pkg::OC_RECORD}},
      '{ROW_BYTE, 32'h61,        1'b0, NO_REC},
      '{ROW_BYTE, 32'hff,        1'b0, NO_REC},
      '{ROW_BYTE, 32'hff,        1'b0, NO_REC},
      '{ROW_BYTE, 32'hc0,        1'b0, NO_REC},
      '{ROW_FILL, 32'h0366,      1'b0, NO_REC},
      '{ROW_BYTE, 32'h67,        1'b0, NO_REC},
      '{ROW_FILL, 32'h0600,      1'b0, NO_REC},
      '{ROW_BYTE, 32'h01,        1'b0, NO_REC},
      '{ROW_BYTE, 32'h66,        1'b1, DONE_RESET_REC},
      '{ROW_END,  32'h00,        1'b0, NO_REC}
   };

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   wire                              req_tready;
   logic [7:0]                       req_tdata = 8'h00;
   logic                             req_tlast = 1'b0;
   wire                              rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   wire  [15:0]                      rsp_tdata;
   wire  [1:0]                       rsp_tuser;
   logic                             csr_valid = 1'b0;
   wire                              csr_ready;
   logic [vgmcsc_pkg::CSR_WIDTH-1:0] csr_index = '0;
   logic [15:0]                      csr_data = 16'h0000;

   vgm_command_stream_converter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic [15:0]           tick_divisor = vgmcsc_pkg::SAMPLES_PER_TICK_RESET;
   logic [7:0]            delay_tag = vgmcsc_pkg::DELAY_CODE_RESET;
   logic [7:0]            done_tag = vgmcsc_pkg::DONE_CODE_RESET;
   vgmcsc_pkg::phase_type parse_phase = vgmcsc_pkg::PH_MAGIC;
   logic [31:0]           byte_count = '0;
   logic [31:0]           data_begin = '0;
   logic [31:0]           skip_left = '0;
   logic [2:0]            operand_idx = '0;
   logic [7:0]            held_value = '0;
   logic                  halted = 1'b0;

   rec_type pending_records [$];
   int      mismatch_count = 0;
   int      items_sent = 0;
   int      burst_left = 0;
   bit      steady_flow = 1'b0;

   function automatic void restart_parser();
      parse_phase = vgmcsc_pkg::PH_MAGIC;
      byte_count  = '0;
      data_begin  = '0;
      skip_left   = '0;
      operand_idx = '0;
      held_value  = '0;
      halted      = 1'b0;
   endfunction

   function automatic bit parse_byte(input logic last, input logic [7:0] b, output rec_type rec);
      logic [31:0] pos;
      logic [15:0] samples;
      bit          short_file;
      rec = NO_REC;
      if (last) begin
         short_file = !halted && parse_phase == vgmcsc_pkg::PH_MAGIC;
         restart_parser();
         rec = '{done_tag, 8'h00, vgmcsc_pkg::OC_DONE};
         return short_file;
      end
      if (halted) return 1'b0;
      pos = byte_count;
      if (byte_count != '1) byte_count++;
      case (parse_phase)
         vgmcsc_pkg::PH_MAGIC: begin
            if (b != MAGIC_WORD[pos[1:0]]) held_value = 8'h01;
            if (pos == 32'd3) begin
               if (held_value != '0) begin
                  halted = 1'b1;
                  rec = ERROR_REC;
                  return 1'b1;
               end
               held_value = '0;
               parse_phase = vgmcsc_pkg::PH_HEADER;
            end
         end
         vgmcsc_pkg::PH_HEADER: begin
            if (pos == HDR_OFFSET_POS - 32'd1) begin
               parse_phase = vgmcsc_pkg::PH_OFFSET;
               operand_idx = '0;
               data_begin = '0;
            end
         end
         vgmcsc_pkg::PH_OFFSET: begin
            data_begin |= 32'(b) << (8 * operand_idx[1:0]);
            operand_idx++;
            if (operand_idx >= 3'd4) begin
               operand_idx = '0;
               data_begin += HDR_OFFSET_POS;
               if (data_begin < HDR_END_POS) begin
                  halted = 1'b1;
                  rec = ERROR_REC;
                  return 1'b1;
               end
               skip_left = data_begin - HDR_END_POS;
               parse_phase = (skip_left == '0) ? vgmcsc_pkg::PH_CMD : vgmcsc_pkg::PH_LEAD;
            end
         end
         vgmcsc_pkg::PH_LEAD, vgmcsc_pkg::PH_SKIP: begin
            if (skip_left > '0) skip_left--;
            if (skip_left == '0) parse_phase = vgmcsc_pkg::PH_CMD;
         end
         vgmcsc_pkg::PH_CHIP, vgmcsc_pkg::PH_WAIT: begin
            if (operand_idx == '0) begin
               held_value = b;
               operand_idx = 3'd1;
               return 1'b0;
            end
            samples = {b, held_value};
            if (parse_phase == vgmcsc_pkg::PH_CHIP) begin
               rec = '{held_value, b, vgmcsc_pkg::OC_RECORD};
            end else begin
               rec = '{delay_tag,
                       (tick_divisor == '0) ? 8'hff : 8'(samples / tick_divisor),
                       vgmcsc_pkg::OC_RECORD};
            end
            parse_phase = vgmcsc_pkg::PH_CMD;
            operand_idx = '0;
            return 1'b1;
         end
         vgmcsc_pkg::PH_BLOCK: begin
            if (operand_idx >= 3'd2) skip_left |= 32'(b) << (8 * (operand_idx - 3'd2));
            operand_idx++;
            if (operand_idx >= 3'd6) begin
               operand_idx = '0;
               parse_phase = (skip_left == '0) ? vgmcsc_pkg::PH_CMD : vgmcsc_pkg::PH_SKIP;
            end
         end
         vgmcsc_pkg::PH_CMD: begin
            case (b)
               vgmcsc_pkg::CMD_CHIP_WRITE: begin
                  parse_phase = vgmcsc_pkg::PH_CHIP;
                  operand_idx = '0;
               end
               vgmcsc_pkg::CMD_WAIT: begin
                  parse_phase = vgmcsc_pkg::PH_WAIT;
                  operand_idx = '0;
               end
               vgmcsc_pkg::CMD_WAIT_ONE: begin
                  rec = '{delay_tag, 8'h01, vgmcsc_pkg::OC_RECORD};
                  return 1'b1;
               end
               vgmcsc_pkg::CMD_END: begin
                  halted = 1'b1;
                  rec = '{done_tag, 8'h00, vgmcsc_pkg::OC_DONE};
                  return 1'b1;
               end
               vgmcsc_pkg::CMD_SKIP_THREE: begin
                  parse_phase = vgmcsc_pkg::PH_SKIP;
                  skip_left = 32'd3;
               end
               vgmcsc_pkg::CMD_DATA_BLOCK: begin
                  parse_phase = vgmcsc_pkg::PH_BLOCK;
                  operand_idx = '0;
                  skip_left = '0;
               end
               default: ;
            endcase
         end
         default: parse_phase = vgmcsc_pkg::PH_CMD;
      endcase
      return 1'b0;
   endfunction

   function automatic byte_queue_type header_bytes(input logic [31:0] offset);
      byte_queue_type hb;
      for (int i = 0; i < 4; i++) hb.push_back(MAGIC_WORD[i]);
      while (hb.size() < HDR_OFFSET_POS) hb.push_back(8'($urandom));
      for (int i = 0; i < 4; i++) hb.push_back(offset[8*i +: 8]);
      return hb;
   endfunction

   // Valid stays high across a burst; a gap is only opened when a new burst starts.
   task automatic send_item(input logic last, input logic [7:0] b, input logic typed,
                            input rec_type want);
      rec_type rec;
      bit      hit;
      int      gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (steady_flow) gap = 0;
         else if ($urandom_range(0, 2) == 0) gap = $urandom_range(1, 20);
         else gap = $urandom_range(0, 3);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      hit = parse_byte(last, b, rec);
      if (typed) pending_records.push_back(want);
      else if (hit) pending_records.push_back(rec);
   endtask

   task automatic write_reg(input logic [vgmcsc_pkg::CSR_WIDTH-1:0] idx,
                            input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         vgmcsc_pkg::CSR_SAMPLES_PER_TICK: tick_divisor = val;
         vgmcsc_pkg::CSR_DELAY_CODE:       delay_tag = val[7:0];
         vgmcsc_pkg::CSR_DONE_CODE:        done_tag = val[7:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      while (pending_records.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   logic [15:0] stall_pat = 16'hffff;
   int          stall_age = 0;

   always @(posedge clock) begin
      if (stall_age == 0) begin
         stall_age = $urandom_range(20, 120);
         case ($urandom_range(0, 3))
            0:       stall_pat = 16'hffff;
            1:       stall_pat = 16'h0001;
            default: stall_pat = 16'($urandom) | 16'h0001;
         endcase
      end
      stall_age = stall_age - 1;
      stall_pat = {stall_pat[14:0], stall_pat[15]};
      rsp_tready <= stall_pat[0];
   end

   always @(posedge clock) begin : check_records
      rec_type seen;
      rec_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = '{rsp_tdata[7:0], rsp_tdata[15:8], vgmcsc_pkg::outcome_type'(rsp_tuser)};
         if (pending_records.size() == 0) begin
            $display("%0t: unexpected transfer, reg %02h value %02h outcome %0d",
                     $time, seen.rec_reg, seen.rec_value, seen.outcome);
            mismatch_count++;
         end else begin
            want = pending_records.pop_front();
            if (seen.rec_reg !== want.rec_reg || seen.rec_value !== want.rec_value ||
                seen.outcome !== want.outcome) begin
               $display("%0t: expected reg %02h value %02h outcome %0d, got %02h %02h %0d",
                        $time, want.rec_reg, want.rec_value, want.outcome,
                        seen.rec_reg, seen.rec_value, seen.outcome);
               mismatch_count++;
            end
         end
      end
   end

   initial begin : stimulus
      byte_queue_type hb;
      byte_queue_type body;
      logic [31:0]    offset;
      logic [31:0]    len;
      logic [7:0]     code;
      int             start_count;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < $size(DIRECTED); r++) begin
         case (DIRECTED[r].kind)
            ROW_BYTE: send_item(1'b0, DIRECTED[r].arg[7:0], DIRECTED[r].typed, DIRECTED[r].want);
            ROW_END:  send_item(1'b1, DIRECTED[r].arg[7:0], DIRECTED[r].typed, DIRECTED[r].want);
            ROW_FILL: begin
               repeat (DIRECTED[r].arg[15:8]) send_item(1'b0, DIRECTED[r].arg[7:0], 1'b0, NO_REC);
            end
            ROW_HDR: begin
               hb = header_bytes(DIRECTED[r].arg);
               foreach (hb[i]) begin
                  send_item(1'b0, hb[i], DIRECTED[r].typed && i == hb.size() - 1,
                            DIRECTED[r].want);
               end
            end
            default: ;
         endcase
      end

      for (int ph_n = 0; ph_n < 6; ph_n++) begin
         if (ph_n > 0) begin
            req_tvalid <= 1'b0;
            drain();
            case (ph_n)
               1: begin
                  write_reg(vgmcsc_pkg::CSR_SAMPLES_PER_TICK, 16'd1);
                  write_reg(vgmcsc_pkg::CSR_DELAY_CODE, 16'h00ff);
                  write_reg(vgmcsc_pkg::CSR_DONE_CODE, 16'h0000);
               end
               2: begin
                  write_reg(vgmcsc_pkg::CSR_SAMPLES_PER_TICK, 16'd0);
                  write_reg(vgmcsc_pkg::CSR_DELAY_CODE, 16'hff00);
                  write_reg(vgmcsc_pkg::CSR_DONE_CODE, 16'h00ff);
                  write_reg(CSR_UNUSED, 16'hffff);
               end
               3: begin
                  write_reg(vgmcsc_pkg::CSR_SAMPLES_PER_TICK, 16'hffff);
                  write_reg(vgmcsc_pkg::CSR_DELAY_CODE, 16'($urandom));
                  write_reg(vgmcsc_pkg::CSR_DONE_CODE, 16'($urandom));
               end
               default: begin
                  write_reg(vgmcsc_pkg::CSR_SAMPLES_PER_TICK,
                            $urandom_range(0, 1) ? 16'($urandom_range(1, 3000))
                                                 : 16'($urandom));
                  write_reg(vgmcsc_pkg::CSR_DELAY_CODE, 16'($urandom));
                  write_reg(vgmcsc_pkg::CSR_DONE_CODE, 16'($urandom));
               end
            endcase
            csr_valid <= 1'b0;
         end

         start_count = items_sent;
         while (items_sent - start_count < 40) begin
            steady_flow = ($urandom_range(0, 3) == 0);
            body.delete();
            case ($urandom_range(0, 19))
               0: begin
                  repeat ($urandom_range(0, 3)) begin
                     body.push_back($urandom_range(0, 1) ? MAGIC_WORD[body.size()]
                                                         : 8'($urandom));
                  end
               end
               1, 2: begin
                  if ($urandom_range(0, 1)) begin
                     for (int i = 0; i < 4; i++) body.push_back(MAGIC_WORD[i]);
                     code = 8'(1 << $urandom_range(0, 7));
                     offset = $urandom_range(0, 3);
                     body[offset] = body[offset] ^ code;
                  end
                  repeat ($urandom_range(0, 12)) body.push_back(8'($urandom));
               end
               3: begin
                  if ($urandom_range(0, 1)) offset = $urandom_range(0, 3);
                  else offset = 32'hffff_ffcc + 32'($urandom_range(0, 51));
                  body = header_bytes(offset);
                  repeat ($urandom_range(0, 4)) body.push_back(8'($urandom));
               end
               default: begin
                  offset = $urandom_range(4, 12);
                  body = header_bytes(offset);
                  repeat (offset - 4) body.push_back(8'($urandom));
                  repeat ($urandom_range(3, 16)) begin
                     case ($urandom_range(0, 9))
                        0, 1, 8: begin
                           body.push_back(vgmcsc_pkg::CMD_CHIP_WRITE);
                           repeat (2) body.push_back(8'($urandom));
                        end
                        2, 3, 9: begin
                           body.push_back(vgmcsc_pkg::CMD_WAIT);
                           repeat (2) body.push_back(8'($urandom));
                        end
                        4: body.push_back(vgmcsc_pkg::CMD_WAIT_ONE);
                        5: begin
                           body.push_back(vgmcsc_pkg::CMD_SKIP_THREE);
                           repeat (3) body.push_back(8'($urandom));
                        end
                        6: begin
                           body.push_back(vgmcsc_pkg::CMD_DATA_BLOCK);
                           repeat (2) body.push_back(8'($urandom));
                           len = $urandom_range(0, 5);
                           for (int i = 0; i < 4; i++) body.push_back(len[8*i +: 8]);
                           repeat (len) body.push_back(8'($urandom));
                        end
                        default: begin
                           do code = 8'($urandom);
                           while (code inside {vgmcsc_pkg::CMD_CHIP_WRITE, vgmcsc_pkg::CMD_WAIT,
                                               vgmcsc_pkg::CMD_WAIT_ONE, vgmcsc_pkg::CMD_END,
                                               vgmcsc_pkg::CMD_SKIP_THREE,
                                               vgmcsc_pkg::CMD_DATA_BLOCK});
                           body.push_back(code);
                        end
                     endcase
                  end
                  if ($urandom_range(0, 4) != 0) begin
                     body.push_back(vgmcsc_pkg::CMD_END);
                     repeat ($urandom_range(0, 3)) body.push_back(8'($urandom));
                  end else begin
                     repeat ($urandom_range(0, 2)) void'(body.pop_back());
                  end
               end
            endcase
            foreach (body[i]) send_item(1'b0, body[i], 1'b0, NO_REC);
            send_item(1'b1, 8'($urandom), 1'b0, NO_REC);
         end
      end

      req_tvalid <= 1'b0;
      drain();
      if (mismatch_count == 0) begin
         $display("vgm_command_stream_converter_tb passed");
      end else begin
         $display("vgm_command_stream_converter_tb failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("vgm_command_stream_converter_tb failed");
      $finish;
   end

endmodule

`default_nettype wire

// File: vgm_command_stream_converter.f
rtl/vgmcsc_pkg.sv
rtl/vgmcsc_div.sv
rtl/vgm_command_stream_converter.sv
dv/vgm_command_stream_converter_tb.sv
